// ===== rtl/sfe_pkg.sv =====
`timescale 1ns / 1ps

package sfe_pkg;

   typedef enum logic [1:0] {
      MODE_NUMBER  = 2'd0,
      MODE_SECONDS = 2'd1,
      MODE_RAW     = 2'd2,
      MODE_DISPLAY = 2'd3
   } mode_type;

   localparam logic [13:0] NUM_MAX      = 14'd9999;
   localparam logic [13:0] SEC_MAX      = 14'd5999;
   localparam logic [7:0]  CMD_DISPLAY  = 8'h48;
   localparam logic [7:0]  SEG_DOT      = 8'h80;
   localparam logic [6:0]  DIV_NUMBER   = 7'd100;
   localparam logic [6:0]  DIV_SECONDS  = 7'd60;
   // floor(n * RECIP >> RECIP_SHIFT) is exact for the clamped ranges
   localparam logic [14:0] RECIP_NUMBER  = 15'd10486;
   localparam logic [14:0] RECIP_SECONDS = 15'd17477;
   localparam int          RECIP_SHIFT   = 20;
   localparam logic [1:0]  DOT_DIGIT     = 2'd1;
   localparam logic [1:0]  LAST_DIGIT    = 2'd3;
   localparam int          QUEUE_DEPTH   = 2;
   localparam int          QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int          QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             is_digits;
      logic [3:0][3:0]  digits;
      logic [7:0]       address;
      logic [7:0]       data;
   } entry_type;

   function automatic logic [7:0] seg_glyph(input logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'h0: g = 8'h3F;
         4'h1: g = 8'h06;
         4'h2: g = 8'h5B;
         4'h3: g = 8'h4F;
         4'h4: g = 8'h66;
         4'h5: g = 8'h6D;
         4'h6: g = 8'h7D;
         4'h7: g = 8'h07;
         4'h8: g = 8'h7F;
         4'h9: g = 8'h6F;
         4'hA: g = 8'h77;
         4'hB: g = 8'h7C;
         4'hC: g = 8'h39;
         4'hD: g = 8'h5E;
         4'hE: g = 8'h79;
         4'hF: g = 8'h71;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] digit_address(input logic [1:0] idx);
      logic [7:0] a;
      case (idx)
         2'd0: a = 8'h68;
         2'd1: a = 8'h6A;
         2'd2: a = 8'h6C;
         2'd3: a = 8'h6E;
         default: a = 8'h68;
      endcase
      return a;
   endfunction

   // two decimal digits of a value below 100, tens in the upper nibble
   function automatic logic [7:0] dec_split(input logic [6:0] x);
      logic [3:0] t;
      logic [6:0] base;
      logic [6:0] u;
      t = 4'd0;
      for (int i = 1; i <= 9; i++) begin
         if (x >= 7'(10 * i)) begin
            t = 4'(i);
         end
      end
      base = {t, 3'b000} + {2'b00, t, 1'b0};
      u = x - base;
      return {t, u[3:0]};
   endfunction

endpackage

// ===== rtl/sfe_if.sv =====
`timescale 1ns / 1ps

interface sfe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] value;
   logic [7:0]  raw_address;
   logic [7:0]  raw_segments;
   logic [7:0]  brightness;
   logic        display_on;

   modport source (
      output valid, mode, value, raw_address, raw_segments, brightness, display_on,
      input  ready
   );
   modport sink (
      input  valid, mode, value, raw_address, raw_segments, brightness, display_on,
      output ready
   );
endinterface

interface sfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_address;
   logic [7:0] frame_data;
   logic       last_frame;

   modport source (
      output valid, frame_address, frame_data, last_frame,
      input  ready
   );
   modport sink (
      input  valid, frame_address, frame_data, last_frame,
      output ready
   );
endinterface

// ===== rtl/sfe_front.sv =====
`timescale 1ns / 1ps

module sfe_front (
   input  logic              clock,
   input  logic              reset,
   sfe_req_if.sink           req,
   output sfe_pkg::entry_type push_entry,
   output logic              push_valid,
   input  logic              push_ready
);
   import sfe_pkg::*;

   // stage 1: clamped value and frame bytes
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_digits_ff, s1_seconds_ff;
   logic [13:0] s1_n_ff;
   logic [7:0]  s1_address_ff, s1_data_ff;
   // stage 2: high part of the split
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_digits_ff, s2_seconds_ff;
   logic [13:0] s2_n_ff;
   logic [6:0]  s2_q_ff, s2_q_in;
   logic [7:0]  s2_address_ff, s2_data_ff;
   // stage 3: both halves below 100
   logic        s3_valid_ff, s3_valid_in;
   logic        s3_digits_ff;
   logic [6:0]  s3_hi_ff, s3_lo_ff, s3_lo_in;
   logic [7:0]  s3_address_ff, s3_data_ff;

   logic        s1_en, s2_en, s3_en;
   mode_type    req_mode;
   logic [13:0] limit;
   logic [13:0] n_in;
   logic [7:0]  address_in, data_in;
   logic [28:0] product;
   logic [13:0] sub_term;
   logic [13:0] remainder;
   logic [7:0]  hi_split, lo_split;

   assign s3_en = !s3_valid_ff || push_ready;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req.ready = s1_en;

   assign req_mode = mode_type'(req.mode);

   always_comb begin
      limit = (req_mode == MODE_SECONDS) ? SEC_MAX : NUM_MAX;
      n_in  = (req.value > {2'b00, limit}) ? limit : req.value[13:0];
      if (req_mode == MODE_RAW) begin
         address_in = req.raw_address;
         data_in    = req.raw_segments;
      end else begin
         address_in = CMD_DISPLAY;
         data_in    = req.brightness | {7'd0, req.display_on};
      end
   end

   assign s1_valid_in = req.valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;

   always_comb begin
      product = {15'd0, s1_n_ff} * {14'd0, (s1_seconds_ff ? RECIP_SECONDS : RECIP_NUMBER)};
      s2_q_in = product[RECIP_SHIFT +: 7];
   end

   always_comb begin
      sub_term  = {7'd0, s2_q_ff} * {7'd0, (s2_seconds_ff ? DIV_SECONDS : DIV_NUMBER)};
      remainder = s2_n_ff - sub_term;
      s3_lo_in  = remainder[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_en) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (s3_en) begin
            s3_valid_ff <= s3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_digits_ff  <= (req_mode == MODE_NUMBER) || (req_mode == MODE_SECONDS);
         s1_seconds_ff <= (req_mode == MODE_SECONDS);
         s1_n_ff       <= n_in;
         s1_address_ff <= address_in;
         s1_data_ff    <= data_in;
      end
      if (s2_en) begin
         s2_digits_ff  <= s1_digits_ff;
         s2_seconds_ff <= s1_seconds_ff;
         s2_n_ff       <= s1_n_ff;
         s2_q_ff       <= s2_q_in;
         s2_address_ff <= s1_address_ff;
         s2_data_ff    <= s1_data_ff;
      end
      if (s3_en) begin
         s3_digits_ff  <= s2_digits_ff;
         s3_hi_ff      <= s2_q_ff;
         s3_lo_ff      <= s3_lo_in;
         s3_address_ff <= s2_address_ff;
         s3_data_ff    <= s2_data_ff;
      end
   end

   always_comb begin
      hi_split = dec_split(s3_hi_ff);
      lo_split = dec_split(s3_lo_ff);
      push_entry.is_digits = s3_digits_ff;
      push_entry.digits    = {lo_split[3:0], lo_split[7:4], hi_split[3:0], hi_split[7:4]};
      push_entry.address   = s3_address_ff;
      push_entry.data      = s3_data_ff;
   end

   assign push_valid = s3_valid_ff;

endmodule

// ===== rtl/sfe_queue.sv =====
`timescale 1ns / 1ps

module sfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  sfe_pkg::entry_type push_entry,
   input  logic               push_valid,
   output logic               push_ready,
   output sfe_pkg::entry_type pop_entry,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import sfe_pkg::*;

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/sfe_back.sv =====
`timescale 1ns / 1ps

module sfe_back (
   input  logic               clock,
   input  logic               reset,
   input  sfe_pkg::entry_type pop_entry,
   input  logic               pop_valid,
   output logic               pop_ready,
   sfe_rsp_if.source          rsp
);
   import sfe_pkg::*;

   entry_type   cur_ff;
   logic        cur_valid_ff;
   logic [1:0]  idx_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_address_ff, rsp_address_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        emit;
   logic        do_pop;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign emit      = cur_valid_ff && out_free;
   assign rsp_last_in = !cur_ff.is_digits || (idx_ff == LAST_DIGIT);
   assign pop_ready = !cur_valid_ff || (emit && rsp_last_in);
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      if (cur_ff.is_digits) begin
         rsp_address_in = digit_address(idx_ff);
         rsp_data_in    = seg_glyph(cur_ff.digits[idx_ff]) |
                          ((idx_ff == DOT_DIGIT) ? SEG_DOT : 8'h00);
      end else begin
         rsp_address_in = cur_ff.address;
         rsp_data_in    = cur_ff.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (emit && rsp_last_in) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         cur_ff <= pop_entry;
      end
      if (emit) begin
         rsp_address_ff <= rsp_address_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.frame_address = rsp_address_ff;
   assign rsp.frame_data    = rsp_data_ff;
   assign rsp.last_frame    = rsp_last_ff;

   a_idx_only_digits: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> (cur_valid_ff && cur_ff.is_digits))
      else $error("frame index advanced outside a digit transaction");

   a_single_frame_last: assert property (@(posedge clock) disable iff (reset)
      (emit && !cur_ff.is_digits) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("single frame transaction not marked last");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (cur_valid_ff && idx_ff == 2'd0))
      else $error("new transaction did not start at first frame");

endmodule

// ===== rtl/four_digit_segment_frame_encoder_unit.sv =====
`timescale 1ns / 1ps
// path: three split stages, then a 2-entry queue that decouples them, then the back end
// throughput: one frame per cycle from the output stage while rsp ready is high, so a
//   digit request gives four frames and a raw or display request gives one frame
// the three-stage digit split accepts a request every cycle unless the queue is full
// reset: synchronous, clears all valid flags and the queue; nothing is pending afterward

module four_digit_segment_frame_encoder_unit (
   input  logic      clock,
   input  logic      reset,
   sfe_req_if.sink   req_port,
   sfe_rsp_if.source rsp_port
);
   import sfe_pkg::*;

   entry_type push_entry, pop_entry;
   logic      push_valid, push_ready;
   logic      pop_valid, pop_ready;

   sfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   sfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   sfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp_port)
   );

endmodule
